FILE: hw/rtl/ternary_zero_group_stats_assert.svh
// Assertion macros used by the ternary zero-group statistics RTL.
// Expects clk and rst to be visible in the including module.
`ifndef TERNARY_ZERO_GROUP_STATS_ASSERT_SVH
`define TERNARY_ZERO_GROUP_STATS_ASSERT_SVH

// Same-cycle implication.
`define TZGS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TZGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/tzgs_pkg.sv
// Package for the ternary zero-group statistics block: constants, codes,
// word and command types. No dependencies.
package tzgs_pkg;

  localparam int GROUP_BYTES_DEF  = 32;
  localparam int COUNTER_BITS_DEF = 48;
  localparam int NUM_CLASSES_DEF  = 4;

  localparam int WORD_BITS  = 64;
  localparam int CODE_BITS  = 2;
  localparam int WORD_CODES = 32;
  localparam int LANES      = 4;
  localparam int LANE_CODES = WORD_CODES / LANES;
  localparam int LANE_BITS  = LANE_CODES * CODE_BITS;
  localparam int LANE_CNT_W = $clog2(LANE_CODES + 1);
  localparam int WORD_CNT_W = $clog2(WORD_CODES + 1);

  // Group counts sized for the largest group (256 bytes, 1024 codes).
  localparam int GCNT_W    = 11;
  localparam int CLS_MAX_W = 3;

  localparam int NUM_COUNTERS = 11;
  localparam int SEL_W        = 4;
  localparam int BKT_W        = 3;
  localparam int RES_CNT_W    = 8;
  localparam int VALUE_W      = 48;

  localparam logic [CODE_BITS-1:0] ZERO_CODE      = 2'b01;
  localparam logic [CODE_BITS-1:0] FORBIDDEN_CODE = 2'b11;

  localparam logic [SEL_W-1:0] CNT_ZEROS     = 4'd0;
  localparam logic [SEL_W-1:0] CNT_FORBIDDEN = 4'd1;
  localparam logic [SEL_W-1:0] CNT_GROUPS    = 4'd2;
  localparam logic [SEL_W-1:0] CNT_ZGROUPS   = 4'd3;
  localparam logic [SEL_W-1:0] CNT_HIST0     = 4'd4;
  localparam logic [SEL_W-1:0] CNT_TENSORS   = 4'd10;

  localparam int NUM_BUCKETS = 6;
  localparam logic [BKT_W-1:0] BKT_NONE = 3'd0;
  localparam logic [BKT_W-1:0] BKT_FULL = 3'd5;

  localparam logic RK_GROUP = 1'b0;
  localparam logic RK_READ  = 1'b1;

  typedef enum logic [1:0] {
    OP_DATA   = 2'd0,
    OP_TENSOR = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_GROUP  = 2'd0,
    CMD_TENSOR = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_op_t;

  typedef struct packed {
    op_t                  opcode;
    logic [1:0]           class_id;
    logic [WORD_BITS-1:0] data_word;
    logic [SEL_W-1:0]     counter_select;
  } item_t;

  typedef struct packed {
    logic                 result_kind;
    logic [RES_CNT_W-1:0] group_zero_count;
    logic [RES_CNT_W-1:0] group_forbidden_count;
    logic [BKT_W-1:0]     group_bucket;
    logic                 all_zero_group;
    logic [VALUE_W-1:0]   counter_value;
  } result_t;

  typedef struct packed {
    logic [LANE_CNT_W-1:0] zeros;
    logic [LANE_CNT_W-1:0] forbidden;
  } lane_cnt_t;

  // Command from the group accumulator to the counter bank.
  typedef struct packed {
    logic                 valid;
    cmd_op_t              op;
    logic [CLS_MAX_W-1:0] row;
    logic [GCNT_W-1:0]    zeros;
    logic [GCNT_W-1:0]    forbidden;
    logic [SEL_W-1:0]     sel;
  } cmd_t;

endpackage

FILE: hw/rtl/tzgs_lane.sv
// One counting lane: zero and forbidden codes in a slice of the input word.
// Depends on tzgs_pkg.
module tzgs_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic [tzgs_pkg::LANE_BITS-1:0]   codes,
  output tzgs_pkg::lane_cnt_t              cnt
);

  logic [tzgs_pkg::LANE_CNT_W-1:0] zc;
  logic [tzgs_pkg::LANE_CNT_W-1:0] fc;

  always_comb begin
    zc = '0;
    fc = '0;
    for (int i = 0; i < tzgs_pkg::LANE_CODES; i++) begin
      if (codes[i*tzgs_pkg::CODE_BITS +: tzgs_pkg::CODE_BITS] == tzgs_pkg::ZERO_CODE) begin
        zc = zc + 1'b1;
      end
      if (codes[i*tzgs_pkg::CODE_BITS +: tzgs_pkg::CODE_BITS] == tzgs_pkg::FORBIDDEN_CODE) begin
        fc = fc + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt.zeros     <= zc;
      cnt.forbidden <= fc;
    end
  end

endmodule

FILE: hw/rtl/tzgs_group_acc.sv
// Merge stage: sums the lane counts, tracks the group position, partial
// counts and current class, and issues commands to the counter bank. Uses tzgs_pkg.
module tzgs_group_acc #(
  parameter int GROUP_BYTES = tzgs_pkg::GROUP_BYTES_DEF,
  parameter int NUM_CLASSES = tzgs_pkg::NUM_CLASSES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           valid,
  input  tzgs_pkg::op_t                  op,
  input  logic [1:0]                     class_id,
  input  logic [tzgs_pkg::SEL_W-1:0]     counter_select,
  input  tzgs_pkg::lane_cnt_t            lanes [tzgs_pkg::LANES],
  output tzgs_pkg::cmd_t                 cmd
);

  localparam int GROUP_WORDS = (GROUP_BYTES / 8 < 1) ? 1 : GROUP_BYTES / 8;
  localparam int GROUP_CODES = GROUP_WORDS * tzgs_pkg::WORD_CODES;
  localparam int ZW          = $clog2(GROUP_CODES + 1);
  localparam int WPW         = (GROUP_WORDS > 1) ? $clog2(GROUP_WORDS) : 1;
  localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  logic [WPW-1:0]   word_position, word_position_next;
  logic [ZW-1:0]    partial_zero_count, partial_zero_count_next;
  logic [ZW-1:0]    partial_forbidden_count, partial_forbidden_count_next;
  logic [CLS_W-1:0] current_class, current_class_next;
  tzgs_pkg::cmd_t   cmd_next;

  logic [tzgs_pkg::WORD_CNT_W-1:0] word_z;
  logic [tzgs_pkg::WORD_CNT_W-1:0] word_f;
  logic [ZW-1:0]                   sum_z;
  logic [ZW-1:0]                   sum_f;
  logic                            last_word;
  logic [CLS_W-1:0]                cls_sel;

  always_comb begin
    word_z = '0;
    word_f = '0;
    for (int i = 0; i < tzgs_pkg::LANES; i++) begin
      word_z = word_z + tzgs_pkg::WORD_CNT_W'(lanes[i].zeros);
      word_f = word_f + tzgs_pkg::WORD_CNT_W'(lanes[i].forbidden);
    end
  end

  assign sum_z     = partial_zero_count + ZW'(word_z);
  assign sum_f     = partial_forbidden_count + ZW'(word_f);
  assign last_word = (word_position == WPW'(GROUP_WORDS - 1));
  // out-of-range class folds onto the last class
  assign cls_sel   = ({2'b00, class_id} >= 4'(NUM_CLASSES)) ?
                     CLS_W'(NUM_CLASSES - 1) : CLS_W'(class_id);

  always_comb begin
    word_position_next           = word_position;
    partial_zero_count_next      = partial_zero_count;
    partial_forbidden_count_next = partial_forbidden_count;
    current_class_next           = current_class;
    cmd_next                     = '0;
    cmd_next.sel                 = counter_select;
    if (valid) begin
      case (op)
        tzgs_pkg::OP_DATA: begin
          if (last_word) begin
            word_position_next           = '0;
            partial_zero_count_next      = '0;
            partial_forbidden_count_next = '0;
            cmd_next.valid               = 1'b1;
            cmd_next.op                  = tzgs_pkg::CMD_GROUP;
            cmd_next.row                 = tzgs_pkg::CLS_MAX_W'(current_class);
            cmd_next.zeros               = tzgs_pkg::GCNT_W'(sum_z);
            cmd_next.forbidden           = tzgs_pkg::GCNT_W'(sum_f);
          end else begin
            word_position_next           = word_position + 1'b1;
            partial_zero_count_next      = sum_z;
            partial_forbidden_count_next = sum_f;
          end
        end
        tzgs_pkg::OP_TENSOR: begin
          current_class_next           = cls_sel;
          word_position_next           = '0;
          partial_zero_count_next      = '0;
          partial_forbidden_count_next = '0;
          cmd_next.valid               = 1'b1;
          cmd_next.op                  = tzgs_pkg::CMD_TENSOR;
          cmd_next.row                 = tzgs_pkg::CLS_MAX_W'(cls_sel);
        end
        tzgs_pkg::OP_READ: begin
          cmd_next.valid = 1'b1;
          cmd_next.op    = tzgs_pkg::CMD_READ;
          cmd_next.row   = tzgs_pkg::CLS_MAX_W'(cls_sel);
        end
        tzgs_pkg::OP_CLEAR: begin
          cmd_next.valid = 1'b1;
          cmd_next.op    = tzgs_pkg::CMD_CLEAR;
        end
        default: begin
          cmd_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_position           <= '0;
      partial_zero_count      <= '0;
      partial_forbidden_count <= '0;
      current_class           <= '0;
      cmd                     <= '0;
    end else if (en) begin
      word_position           <= word_position_next;
      partial_zero_count      <= partial_zero_count_next;
      partial_forbidden_count <= partial_forbidden_count_next;
      current_class           <= current_class_next;
      cmd                     <= cmd_next;
    end
  end

endmodule

FILE: hw/rtl/tzgs_counter_bank.sv
// Per-class saturating counters: one memory row per class, read then
// updated a stage later with write bypass; drives the result register. Uses tzgs_pkg.
`include "ternary_zero_group_stats_assert.svh"

module tzgs_counter_bank #(
  parameter int GROUP_BYTES  = tzgs_pkg::GROUP_BYTES_DEF,
  parameter int COUNTER_BITS = tzgs_pkg::COUNTER_BITS_DEF,
  parameter int NUM_CLASSES  = tzgs_pkg::NUM_CLASSES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  tzgs_pkg::cmd_t    cmd,
  output logic              result_valid,
  output tzgs_pkg::result_t result
);

  localparam int GROUP_WORDS = (GROUP_BYTES / 8 < 1) ? 1 : GROUP_BYTES / 8;
  localparam int GROUP_CODES = GROUP_WORDS * tzgs_pkg::WORD_CODES;
  localparam int CLS_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int RW          = tzgs_pkg::NUM_COUNTERS * COUNTER_BITS;
  localparam int ZQ_W        = tzgs_pkg::GCNT_W + 2;

  logic [RW-1:0]          mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] row_valid;

  // read stage
  logic [CLS_W-1:0]              rd_row;
  logic [ZQ_W-1:0]               z4;
  logic [tzgs_pkg::BKT_W-1:0]    bucket_next;
  logic                          all_zero_next;

  // update stage
  tzgs_pkg::cmd_t                s4;
  logic [RW-1:0]                 rd_data;
  logic                          rd_valid;
  logic [tzgs_pkg::BKT_W-1:0]    bucket;
  logic                          all_zero;
  logic                          byp_valid;
  logic [CLS_W-1:0]              byp_row;
  logic [RW-1:0]                 byp_data;
  logic                          clr_seen;

  logic [CLS_W-1:0]              s4_row;
  logic [RW-1:0]                 cur_row;
  logic [RW-1:0]                 row_new;
  logic [COUNTER_BITS-1:0]       cnt [tzgs_pkg::NUM_COUNTERS];
  logic [tzgs_pkg::GCNT_W-1:0]   inc [tzgs_pkg::NUM_COUNTERS];
  logic [COUNTER_BITS-1:0]       sel_cnt;
  logic [63:0]                   sel_wide;
  logic                          wr_en;
  logic                          s4_clear;
  tzgs_pkg::result_t             result_next;

  function automatic logic [COUNTER_BITS-1:0] sat_add(
    input logic [COUNTER_BITS-1:0]     a,
    input logic [tzgs_pkg::GCNT_W-1:0] b
  );
    logic [COUNTER_BITS:0] s;
    s = {1'b0, a} + (COUNTER_BITS + 1)'(b);
    return s[COUNTER_BITS] ? '1 : s[COUNTER_BITS-1:0];
  endfunction

  // bucket = 1 + floor(4z / group codes), with the empty and full groups apart
  assign rd_row = cmd.row[CLS_W-1:0];
  assign z4     = {cmd.zeros, 2'b00};

  always_comb begin
    all_zero_next = (cmd.zeros == tzgs_pkg::GCNT_W'(GROUP_CODES));
    if (cmd.zeros == '0) begin
      bucket_next = tzgs_pkg::BKT_NONE;
    end else if (cmd.zeros >= tzgs_pkg::GCNT_W'(GROUP_CODES)) begin
      bucket_next = tzgs_pkg::BKT_FULL;
    end else begin
      bucket_next = 3'd1 + 3'(z4 >= ZQ_W'(GROUP_CODES))
                         + 3'(z4 >= ZQ_W'(2 * GROUP_CODES))
                         + 3'(z4 >= ZQ_W'(3 * GROUP_CODES));
    end
  end

  assign s4_row   = s4.row[CLS_W-1:0];
  assign s4_clear = s4.valid && (s4.op == tzgs_pkg::CMD_CLEAR);
  assign wr_en    = s4.valid && ((s4.op == tzgs_pkg::CMD_GROUP) ||
                                 (s4.op == tzgs_pkg::CMD_TENSOR));

  // a clear or a write by the previous command is not yet in the registered read data
  always_comb begin
    if (clr_seen) begin
      cur_row = '0;
    end else if (byp_valid && (byp_row == s4_row)) begin
      cur_row = byp_data;
    end else if (rd_valid) begin
      cur_row = rd_data;
    end else begin
      cur_row = '0;
    end
  end

  always_comb begin
    for (int i = 0; i < tzgs_pkg::NUM_COUNTERS; i++) begin
      cnt[i] = cur_row[i*COUNTER_BITS +: COUNTER_BITS];
      inc[i] = '0;
    end
    if (s4.valid) begin
      case (s4.op)
        tzgs_pkg::CMD_GROUP: begin
          inc[tzgs_pkg::CNT_ZEROS]     = s4.zeros;
          inc[tzgs_pkg::CNT_FORBIDDEN] = s4.forbidden;
          inc[tzgs_pkg::CNT_GROUPS]    = tzgs_pkg::GCNT_W'(1);
          inc[tzgs_pkg::CNT_ZGROUPS]   = tzgs_pkg::GCNT_W'(all_zero);
          for (int k = 0; k < tzgs_pkg::NUM_BUCKETS; k++) begin
            if (bucket == tzgs_pkg::BKT_W'(k)) begin
              inc[int'(tzgs_pkg::CNT_HIST0) + k] = tzgs_pkg::GCNT_W'(1);
            end
          end
        end
        tzgs_pkg::CMD_TENSOR: begin
          inc[tzgs_pkg::CNT_TENSORS] = tzgs_pkg::GCNT_W'(1);
        end
        default: begin
          inc[tzgs_pkg::CNT_ZEROS] = '0;
        end
      endcase
    end
    for (int i = 0; i < tzgs_pkg::NUM_COUNTERS; i++) begin
      row_new[i*COUNTER_BITS +: COUNTER_BITS] = sat_add(cnt[i], inc[i]);
    end
  end

  always_comb begin
    if (s4.sel < tzgs_pkg::SEL_W'(tzgs_pkg::NUM_COUNTERS)) begin
      sel_cnt = cnt[s4.sel];
    end else begin
      sel_cnt = '0;
    end
    sel_wide    = 64'(sel_cnt);
    result_next = '0;
    if (s4.valid && (s4.op == tzgs_pkg::CMD_GROUP)) begin
      result_next.result_kind           = tzgs_pkg::RK_GROUP;
      result_next.group_zero_count      = s4.zeros[tzgs_pkg::RES_CNT_W-1:0];
      result_next.group_forbidden_count = s4.forbidden[tzgs_pkg::RES_CNT_W-1:0];
      result_next.group_bucket          = bucket;
      result_next.all_zero_group        = all_zero;
    end else if (s4.valid && (s4.op == tzgs_pkg::CMD_READ)) begin
      result_next.result_kind   = tzgs_pkg::RK_READ;
      result_next.counter_value = sel_wide[tzgs_pkg::VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4           <= '0;
      result_valid <= 1'b0;
      row_valid    <= '0;
      byp_valid    <= 1'b0;
      clr_seen     <= 1'b0;
    end else if (en) begin
      s4           <= cmd;
      result_valid <= s4.valid && ((s4.op == tzgs_pkg::CMD_GROUP) ||
                                   (s4.op == tzgs_pkg::CMD_READ));
      byp_valid    <= wr_en;
      clr_seen     <= s4_clear;
      if (s4_clear) begin
        row_valid <= '0;
      end else if (wr_en) begin
        row_valid[s4_row] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_data  <= mem[rd_row];
      rd_valid <= row_valid[rd_row];
      bucket   <= bucket_next;
      all_zero <= all_zero_next;
      byp_row  <= s4_row;
      byp_data <= row_new;
      result   <= result_next;
      if (wr_en) begin
        mem[s4_row] <= row_new;
      end
    end
  end

  `TZGS_ASSERT_NOW(a_full_bucket,
                   result_valid && result.all_zero_group,
                   result.group_bucket == tzgs_pkg::BKT_FULL,
                   "all-zero group outside the full bucket")
  `TZGS_ASSERT_NOW(a_read_clean,
                   result_valid && (result.result_kind == tzgs_pkg::RK_READ),
                   (result.group_zero_count == '0) && (result.group_forbidden_count == '0) &&
                   (result.group_bucket == '0) && !result.all_zero_group,
                   "counter read carries group fields")
  `TZGS_ASSERT_NOW(a_report_value,
                   result_valid && (result.result_kind == tzgs_pkg::RK_GROUP),
                   result.counter_value == '0,
                   "group report carries a counter value")
  `TZGS_ASSERT_NEXT(a_clear_rows,
                    en && s4_clear,
                    (row_valid == '0) && clr_seen,
                    "clear did not drop all rows")

endmodule

FILE: hw/rtl/ternary_zero_group_stats.sv
// Ternary zero-group statistics: four lanes count codes of each word, a
// merge stage builds groups, a per-class counter bank updates and reports.
// Path: the lane registers, the merge-stage command, the update-stage command and the result register.
// Throughput: one word per cycle; the pipeline holds only while a result waits and stall is high.
// Reset: synchronous; counters read as zero at once through per-class row valid bits.
module ternary_zero_group_stats #(
  parameter int GROUP_BYTES  = tzgs_pkg::GROUP_BYTES_DEF,
  parameter int COUNTER_BITS = tzgs_pkg::COUNTER_BITS_DEF,
  parameter int NUM_CLASSES  = tzgs_pkg::NUM_CLASSES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  tzgs_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output tzgs_pkg::result_t result
);

  logic                           en;
  logic                           v1;
  tzgs_pkg::op_t                  op1;
  logic [1:0]                     cid1;
  logic [tzgs_pkg::SEL_W-1:0]     sel1;
  tzgs_pkg::lane_cnt_t            lane_cnt [tzgs_pkg::LANES];
  tzgs_pkg::cmd_t                 cmd;

  // whole pipeline advances unless a finished result is held at the output
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1  <= item.opcode;
      cid1 <= item.class_id;
      sel1 <= item.counter_select;
    end
  end

  for (genvar g = 0; g < tzgs_pkg::LANES; g++) begin : g_lane
    tzgs_lane u_lane (
      .clk   (clk),
      .en    (en),
      .codes (item.data_word[g*tzgs_pkg::LANE_BITS +: tzgs_pkg::LANE_BITS]),
      .cnt   (lane_cnt[g])
    );
  end

  tzgs_group_acc #(
    .GROUP_BYTES (GROUP_BYTES),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_group_acc (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .valid          (v1),
    .op             (op1),
    .class_id       (cid1),
    .counter_select (sel1),
    .lanes          (lane_cnt),
    .cmd            (cmd)
  );

  tzgs_counter_bank #(
    .GROUP_BYTES  (GROUP_BYTES),
    .COUNTER_BITS (COUNTER_BITS),
    .NUM_CLASSES  (NUM_CLASSES)
  ) u_counter_bank (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
